// File: sv/bank_switch_mapper_with_scanline_irq_top_assert.svh
// Assertion macros for the bank mapper top level.
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_TOP_ASSERT_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// a holds in this cycle, so b holds in the same cycle
`define BSM_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);

// a holds in this cycle, so b holds in the next one
`define BSM_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);

`else

`define BSM_ASSERT_NOW(label, clk, rst_n, a, b, msg)
`define BSM_ASSERT_NEXT(label, clk, rst_n, a, b, msg)

`endif

`endif

// File: sv/bsm_pkg.sv
// Package for the bank mapper: operation codes, select codes and bank helpers.
`timescale 1ns / 1ps

package bsm_pkg;

  // Default widths of stored bank numbers
  localparam int PRG_BANK_BITS = 6;
  localparam int CHR_BANK_BITS = 8;

  // Program ROM page count after reset
  localparam logic [5:0] PAGE_COUNT_RESET = 6'd32;

  // Operation carried by one input word
  typedef enum logic [2:0] {
    OP_CPU_READ   = 3'd0,
    OP_CPU_WRITE  = 3'd1,
    OP_PPU_READ   = 3'd2,
    OP_SCAN_TICK  = 3'd3,
    OP_IRQ_POLL   = 3'd4
  } op_t;

  // Memory select codes
  localparam logic [1:0] MEM_NONE = 2'd0;
  localparam logic [1:0] MEM_PRG  = 2'd1;
  localparam logic [1:0] MEM_WRAM = 2'd2;
  localparam logic [1:0] MEM_CHR  = 2'd3;

  // Control register groups, address bits 14:13 of a write at 0x8000 and up
  localparam logic [1:0] CTL_BANK   = 2'd0;
  localparam logic [1:0] CTL_MIRROR = 2'd1;
  localparam logic [1:0] CTL_COUNT  = 2'd2;
  localparam logic [1:0] CTL_IRQ    = 2'd3;

  // 8K bank number twice the page count less sub, modulo 256
  function automatic logic [7:0] bank_below(input logic [5:0] pages, input logic [1:0] sub);
    logic [7:0] twice;
    twice = {1'b0, pages, 1'b0};
    return twice - {6'd0, sub};
  endfunction

endpackage

// File: sv/bank_switch_mapper_with_scanline_irq_top.sv
// Bank mapper top level: address translation, control registers, scanline IRQ counter.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | tuser op, tdata address and data
//  out_    | out | out_tvalid / out_tready| tuser mem_select, tdata translated access
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_data program ROM page count
//
// One word a cycle unless the output stalls: each accepted word updates the state at
// the accept edge and its result sits in the output register (the only register on
// the path) the cycle after; in_tready follows out_tready when a result is held.
// Reset (rst_n low, synchronous) restores the power-on banks and clears the IRQ.
// cfg_ready is always high.
`timescale 1ns / 1ps

module bank_switch_mapper_with_scanline_irq_top #(
  parameter int PRG_BANK_BITS = bsm_pkg::PRG_BANK_BITS,
  parameter int CHR_BANK_BITS = bsm_pkg::CHR_BANK_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] op
  input  logic [23:0] in_tdata,   // [15:0] address, [23:16] data
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] mem_select
  output logic [23:0] out_tdata,  // [0] mem_write, [19:1] mem_address,
                                  // [20] mirror_horizontal, [21] irq_line, [22] irq_taken
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data    // program ROM page count
);

  `include "bank_switch_mapper_with_scanline_irq_top_assert.svh"

  logic                     in_acc;
  logic                     cfg_acc;
  logic [15:0]              in_addr;
  logic [7:0]               in_data;
  bsm_pkg::op_t             in_op;

  // architectural state
  logic [5:0]               pages_r, pages_nxt;
  logic [2:0]               target_r, target_nxt;
  logic                     prg_swap_r, prg_swap_nxt;
  logic                     chr_inv_r, chr_inv_nxt;
  logic [7:0]               bank_r [8];
  logic [7:0]               bank_nxt [8];
  logic [PRG_BANK_BITS-1:0] prg_slot_r [4];
  logic [PRG_BANK_BITS-1:0] prg_slot_nxt [4];
  logic [CHR_BANK_BITS-1:0] chr_slot_r [8];
  logic [CHR_BANK_BITS-1:0] chr_slot_nxt [8];
  logic                     mirror_r, mirror_nxt;
  logic [7:0]               count_r, count_nxt;
  logic [7:0]               reload_r, reload_nxt;
  logic                     irq_en_r, irq_en_nxt;
  logic                     irq_pend_r, irq_pend_nxt;

  // output register
  logic                     out_valid_r;
  logic [1:0]               out_sel_r;
  logic                     out_wr_r;
  logic [18:0]              out_addr_r;
  logic                     out_mirror_r;
  logic                     out_irq_r;
  logic                     out_taken_r;

  // result of the word being accepted
  logic [1:0]               res_sel;
  logic                     res_wr;
  logic [18:0]              res_addr;
  logic                     res_taken;
  logic [31:0]              prg_wide;
  logic [31:0]              chr_wide;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign in_addr   = in_tdata[15:0];
  assign in_data   = in_tdata[23:16];
  assign in_op     = bsm_pkg::op_t'(in_tuser);

  // translated addresses from the current slot tables
  assign prg_wide = (32'(prg_slot_r[in_addr[14:13]]) << 13) | {19'd0, in_addr[12:0]};
  assign chr_wide = (32'(chr_slot_r[in_addr[12:10]]) << 10) | {22'd0, in_addr[9:0]};

  // next state and result
  always_comb begin
    pages_nxt    = pages_r;
    target_nxt   = target_r;
    prg_swap_nxt = prg_swap_r;
    chr_inv_nxt  = chr_inv_r;
    bank_nxt     = bank_r;
    prg_slot_nxt = prg_slot_r;
    chr_slot_nxt = chr_slot_r;
    mirror_nxt   = mirror_r;
    count_nxt    = count_r;
    reload_nxt   = reload_r;
    irq_en_nxt   = irq_en_r;
    irq_pend_nxt = irq_pend_r;
    res_sel      = bsm_pkg::MEM_NONE;
    res_wr       = 1'b0;
    res_addr     = 19'd0;
    res_taken    = 1'b0;

    if (in_acc) begin
      case (in_op)
        bsm_pkg::OP_CPU_READ, bsm_pkg::OP_CPU_WRITE: begin
          if (in_addr[15:13] == 3'b011) begin
            // work RAM window
            res_sel  = bsm_pkg::MEM_WRAM;
            res_wr   = (in_op == bsm_pkg::OP_CPU_WRITE);
            res_addr = {6'd0, in_addr[12:0]};
          end else if (in_addr[15]) begin
            if (in_op == bsm_pkg::OP_CPU_READ) begin
              res_sel  = bsm_pkg::MEM_PRG;
              res_addr = prg_wide[18:0];
            end else begin
              // control register write
              case (in_addr[14:13])
                bsm_pkg::CTL_BANK: begin
                  if (!in_addr[0]) begin
                    target_nxt   = in_data[2:0];
                    prg_swap_nxt = in_data[6];
                    chr_inv_nxt  = in_data[7];
                  end else begin
                    bank_nxt[target_r] = in_data;
                    // rebuild CHR slots: pairs in one half, singles in the other
                    for (int i = 0; i < 4; i++) begin
                      chr_slot_nxt[{chr_inv_r, 2'(i)}] =
                        CHR_BANK_BITS'({bank_nxt[3'(i >> 1)][7:1], 1'(i & 1)});
                      chr_slot_nxt[{~chr_inv_r, 2'(i)}] =
                        CHR_BANK_BITS'(bank_nxt[3'(i + 2)]);
                    end
                    // rebuild PRG slots
                    if (prg_swap_r) begin
                      prg_slot_nxt[2] = PRG_BANK_BITS'(bank_nxt[6]);
                      prg_slot_nxt[0] = PRG_BANK_BITS'(bsm_pkg::bank_below(pages_r, 2'd2));
                    end else begin
                      prg_slot_nxt[0] = PRG_BANK_BITS'(bank_nxt[6]);
                      prg_slot_nxt[2] = PRG_BANK_BITS'(bsm_pkg::bank_below(pages_r, 2'd2));
                    end
                    prg_slot_nxt[1] = PRG_BANK_BITS'(bank_nxt[7]);
                    prg_slot_nxt[3] = PRG_BANK_BITS'(bsm_pkg::bank_below(pages_r, 2'd1));
                  end
                end
                bsm_pkg::CTL_MIRROR: begin
                  // odd address is RAM protect, ignored
                  if (!in_addr[0]) mirror_nxt = in_data[0];
                end
                bsm_pkg::CTL_COUNT: begin
                  if (!in_addr[0]) reload_nxt = in_data;
                  else             count_nxt  = 8'd0;
                end
                bsm_pkg::CTL_IRQ: begin
                  if (!in_addr[0]) begin
                    irq_en_nxt   = 1'b0;
                    irq_pend_nxt = 1'b0;
                  end else begin
                    irq_en_nxt   = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        bsm_pkg::OP_PPU_READ: begin
          res_sel  = bsm_pkg::MEM_CHR;
          res_addr = chr_wide[18:0];
        end
        bsm_pkg::OP_SCAN_TICK: begin
          // reload on zero, else count down; raise IRQ on reaching zero when enabled
          if (count_r == 8'd0) count_nxt = reload_r;
          else                 count_nxt = count_r - 8'd1;
          if (count_nxt == 8'd0 && irq_en_r) irq_pend_nxt = 1'b1;
        end
        bsm_pkg::OP_IRQ_POLL: begin
          if (irq_pend_r) begin
            irq_pend_nxt = 1'b0;
            res_taken    = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // page count write refreshes the fixed PRG slots
    if (cfg_acc) begin
      pages_nxt       = cfg_data;
      prg_slot_nxt[3] = PRG_BANK_BITS'(bsm_pkg::bank_below(cfg_data, 2'd1));
      if (prg_swap_r) prg_slot_nxt[0] = PRG_BANK_BITS'(bsm_pkg::bank_below(cfg_data, 2'd2));
      else            prg_slot_nxt[2] = PRG_BANK_BITS'(bsm_pkg::bank_below(cfg_data, 2'd2));
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_r     <= bsm_pkg::PAGE_COUNT_RESET;
      target_r    <= 3'd0;
      prg_swap_r  <= 1'b0;
      chr_inv_r   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        bank_r[i]     <= 8'd0;
        chr_slot_r[i] <= CHR_BANK_BITS'(i);
      end
      prg_slot_r[0] <= '0;
      prg_slot_r[1] <= PRG_BANK_BITS'(1);
      prg_slot_r[2] <= PRG_BANK_BITS'(bsm_pkg::bank_below(bsm_pkg::PAGE_COUNT_RESET, 2'd2));
      prg_slot_r[3] <= PRG_BANK_BITS'(bsm_pkg::bank_below(bsm_pkg::PAGE_COUNT_RESET, 2'd1));
      mirror_r    <= 1'b0;
      count_r     <= 8'd0;
      reload_r    <= 8'd0;
      irq_en_r    <= 1'b0;
      irq_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pages_r     <= pages_nxt;
      target_r    <= target_nxt;
      prg_swap_r  <= prg_swap_nxt;
      chr_inv_r   <= chr_inv_nxt;
      bank_r      <= bank_nxt;
      prg_slot_r  <= prg_slot_nxt;
      chr_slot_r  <= chr_slot_nxt;
      mirror_r    <= mirror_nxt;
      count_r     <= count_nxt;
      reload_r    <= reload_nxt;
      irq_en_r    <= irq_en_nxt;
      irq_pend_r  <= irq_pend_nxt;
      if (in_acc)          out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_sel_r    <= res_sel;
      out_wr_r     <= res_wr;
      out_addr_r   <= res_addr;
      out_mirror_r <= mirror_nxt;
      out_irq_r    <= irq_pend_nxt;
      out_taken_r  <= res_taken;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sel_r;
  assign out_tdata  = {1'b0, out_taken_r, out_irq_r, out_mirror_r, out_addr_r, out_wr_r};

  // checks
  `BSM_ASSERT_NEXT(a_acc_gives_result, clk, rst_n, in_acc, out_valid_r,
    "accepted word left no result")
  `BSM_ASSERT_NEXT(a_poll_clears_irq, clk, rst_n,
    in_acc && (in_op == bsm_pkg::OP_IRQ_POLL), !irq_pend_r,
    "IRQ still pending after poll")
  `BSM_ASSERT_NEXT(a_cfg_last_bank, clk, rst_n, cfg_acc,
    prg_slot_r[3] == PRG_BANK_BITS'(bsm_pkg::bank_below(pages_r, 2'd1)),
    "last PRG slot not fixed after page count write")
  `BSM_ASSERT_NOW(a_taken_clears_line, clk, rst_n, out_valid_r && out_taken_r, !out_irq_r,
    "IRQ line high on a taken poll")

endmodule
